// ----- hw/rtl/bdd_pkg.sv -----
// ----------------------------------------------------------------------------
// bdd_pkg: shared constants for the digit divider
// Field widths of the channels and the default digit size.
// ----------------------------------------------------------------------------
`default_nettype none

package bdd_pkg;

    // width of every digit-sized field on the channels
    localparam int FIELD_W = 60;

    // default working digit size (8 .. 60, at most FIELD_W)
    localparam int DIGIT_BITS_DEF = 60;

endpackage

`default_nettype wire

// ----- hw/rtl/bdd_if.sv -----
// ----------------------------------------------------------------------------
// bdd_if: valid/ready channels of the digit divider
// Input digit channel, result channel and divisor write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// dividend digit channel
interface bdd_in_if;
    import bdd_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] dividend_digit;
    logic               final_digit;
    logic               negative;

    modport source (output valid, output dividend_digit, output final_digit,
                    output negative, input ready);
    modport sink   (input valid, input dividend_digit, input final_digit,
                    input negative, output ready);
endinterface

// result channel
interface bdd_out_if;
    import bdd_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] quotient_digit;
    logic [FIELD_W-1:0] remainder_out;
    logic               last;
    logic               quotient_negative;
    logic               divide_by_zero;

    modport source (output valid, output quotient_digit, output remainder_out,
                    output last, output quotient_negative, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input quotient_digit, input remainder_out,
                    input last, input quotient_negative, input divide_by_zero,
                    output ready);
endinterface

// divisor write channel
interface bdd_cfg_if;
    import bdd_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bignum_divide_by_digit.sv -----
// ----------------------------------------------------------------------------
// bignum_divide_by_digit: short division of a multi-digit number by one digit
// Bit-serial restoring divider, one quotient bit per clock while running.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  writes the divisor (reset value 1); always ready. Write it only
//          while no digit is in flight.
//   i_in   takes one dividend digit per transfer, most significant first;
//          final_digit marks the least significant digit of a number.
//   o_out  returns one result per digit: quotient digit, final remainder
//          (zero unless last), sign copy and the divide-by-zero flag.
// Timing:
//   Each digit is worked on by the single shift/subtract unit, one quotient
//   bit per cycle; its last step can hold, as described below. A new digit
//   is accepted in the cycle after the result is loaded, so a digit is taken
//   only once the one before it is through. The running remainder carries
//   from digit to digit.
// Reset and stall:
//   Reset clears the running remainder and sets the divisor to 1. A result
//   waits in the output register while the receiver stalls; the next digit
//   may still be taken and worked on, and its last step holds until the
//   output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bignum_divide_by_digit #(
    parameter int DIGIT_BITS = bdd_pkg::DIGIT_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bdd_cfg_if.sink    i_cfg,
    bdd_in_if.sink     i_in,
    bdd_out_if.source  o_out
);
    import bdd_pkg::*;

    localparam int W     = DIGIT_BITS;
    localparam int CNT_W = $clog2(DIGIT_BITS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    // state and datapath registers
    logic               r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [FIELD_W-1:0] r_divisor;
    logic [W-1:0]       r_rem, n_rem;
    logic [W-1:0]       r_digit, n_digit;
    logic [W-1:0]       r_quo, n_quo;
    logic               r_final, r_neg, r_dbz;
    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_out_quo, r_out_rem;
    logic               r_out_last, r_out_neg, r_out_dbz;

    // width conversion between fields and digits
    logic [FIELD_W+W-1:0] dvs_ext, dig_ext;
    logic [W-1:0]         dvs, in_digit;
    logic [FIELD_W+W-1:0] q_ext, r_ext;

    // shared step unit
    logic         carry;
    logic [W-1:0] shifted;
    logic         take;
    logic [W-1:0] step_rem;
    logic [W-1:0] step_quo;

    logic in_xfer, slot_free, last_step, finish;
    logic [W-1:0] res_quo, res_rem;

    assign dvs_ext  = {{W{1'b0}}, r_divisor};
    assign dvs      = dvs_ext[W-1:0];
    assign dig_ext  = {{W{1'b0}}, i_in.dividend_digit};
    assign in_digit = dig_ext[W-1:0];

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign slot_free   = !r_out_valid || o_out.ready;
    assign last_step   = (r_state == S_RUN) && (r_cnt == '0);
    assign finish      = last_step && slot_free;

    // one restoring step: shift in the next digit bit, subtract on carry or >=
    always_comb begin
        carry    = r_rem[W-1];
        shifted  = {r_rem[W-2:0], r_digit[W-1]};
        take     = carry || (shifted >= dvs);
        step_rem = take ? (shifted - dvs) : shifted;
        step_quo = {r_quo[W-2:0], take};
    end

    // final result selection: zero on a zero divisor, remainder only on the final digit
    always_comb begin
        res_quo = r_dbz ? '0 : step_quo;
        res_rem = (r_dbz || !r_final) ? '0 : step_rem;
        q_ext   = {{FIELD_W{1'b0}}, res_quo};
        r_ext   = {{FIELD_W{1'b0}}, res_rem};
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_digit     = r_digit;
        n_quo       = r_quo;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_RUN;
                    n_cnt   = CNT_W'(DIGIT_BITS - 1);
                    n_digit = in_digit;
                    n_quo   = '0;
                end
            end
            S_RUN: begin
                if (last_step) begin
                    if (slot_free) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_rem       = (r_dbz || r_final) ? '0 : step_rem;
                    end
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_rem   = step_rem;
                    n_digit = {r_digit[W-2:0], 1'b0};
                    n_quo   = step_quo;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_divisor   <= FIELD_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_divisor <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        r_quo   <= n_quo;
        if (in_xfer) begin
            r_final <= i_in.final_digit;
            r_neg   <= i_in.negative;
            r_dbz   <= (dvs == '0);
        end
        if (finish) begin
            r_out_quo  <= q_ext[FIELD_W-1:0];
            r_out_rem  <= r_ext[FIELD_W-1:0];
            r_out_last <= r_final;
            r_out_neg  <= r_neg;
            r_out_dbz  <= r_dbz;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.quotient_digit    = r_out_quo;
    assign o_out.remainder_out     = r_out_rem;
    assign o_out.last              = r_out_last;
    assign o_out.quotient_negative = r_out_neg;
    assign o_out.divide_by_zero    = r_out_dbz;

endmodule

`default_nettype wire

// ----- hw/rtl/bdd_checker.sv -----
// ----------------------------------------------------------------------------
// bdd_checker: port-level checks for the digit divider
// Watches the top-level channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         i_in_ready,
    input wire                         i_out_valid,
    input wire                         i_out_ready,
    input wire [bdd_pkg::FIELD_W-1:0]  i_quo,
    input wire [bdd_pkg::FIELD_W-1:0]  i_rem,
    input wire                         i_last,
    input wire                         i_dbz
);
    import bdd_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_quo) && $stable(i_rem))
        else $error("result changed while stalled");

    // a digit in work blocks the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted during a division");

    // zero divisor gives zero results
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dbz |-> (i_quo == '0) && (i_rem == '0))
        else $error("nonzero result on divide by zero");

    // remainder shows only on the last digit
    a_rem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> (i_rem == '0))
        else $error("remainder on a digit that is not last");

endmodule

bind bignum_divide_by_digit bdd_checker u_bdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_quo       (o_out.quotient_digit),
    .i_rem       (o_out.remainder_out),
    .i_last      (o_out.last),
    .i_dbz       (o_out.divide_by_zero)
);

`default_nettype wire

// ----- tb/tb_bignum_divide_by_digit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bignum_divide_by_digit: self-checking bench for the digit divider
// Feeds multi-digit dividends, most significant digit first, under a range of
// divisor settings. A bit-serial restoring divider written here predicts
// every result. Each result transfer is then compared field by field with
// the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_bignum_divide_by_digit;
    import bdd_pkg::*;

    localparam int FW = FIELD_W;
    localparam int DW = DIGIT_BITS_DEF;
    localparam logic [FW-1:0] DIGIT_MASK = {FW{1'b1}} >> (FW - DW);
    localparam logic [FW-1:0] MAX_DIGIT  = DIGIT_MASK;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = DW + 20;

    typedef struct packed {
        logic [FW-1:0] quotient_digit;
        logic [FW-1:0] remainder_out;
        logic          last;
        logic          quotient_negative;
        logic          divide_by_zero;
    } div_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bdd_cfg_if cfg_ch ();
    bdd_in_if  in_ch ();
    bdd_out_if out_ch ();

    bignum_divide_by_digit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // local copy of the divider state
    logic [FW-1:0] model_divisor   = FW'(1);
    logic [FW-1:0] model_remainder = '0;
    div_result_t   expected_quotients[$];

    int  error_count    = 0;
    int  digit_count    = 0;
    int  number_count   = 0;
    int  checked_count  = 0;
    int  zero_div_count = 0;
    int  divisor_writes = 0;
    bit  no_idle        = 1'b0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop if the run hangs
    initial begin
        #6_000_000;
        $error("timeout: %0d results still expected", expected_quotients.size());
        $display("tb_bignum_divide_by_digit: FAIL");
        $finish;
    end

    // one restoring step per quotient bit, MSB first; updates the running remainder
    function automatic div_result_t divide_next_digit(input logic [FW-1:0] digit,
                                                      input logic fin, input logic neg);
        div_result_t   res;
        logic [FW-1:0] dvs;
        logic [FW-1:0] r;
        logic [FW-1:0] q;
        logic          carry;
        res = '0;
        res.last = fin;
        res.quotient_negative = neg;
        dvs = model_divisor & DIGIT_MASK;
        if (dvs == '0) begin
            res.divide_by_zero = 1'b1;
            model_remainder = '0;
        end else begin
            r = model_remainder & DIGIT_MASK;
            q = '0;
            for (int i = DW - 1; i >= 0; i--) begin
                carry = r[DW-1];
                r = ((r << 1) | FW'(digit[i])) & DIGIT_MASK;
                q = (q << 1) & DIGIT_MASK;
                // shifted-out bit set means the true value exceeds the divisor
                if (carry || r >= dvs) begin
                    r = (r - dvs) & DIGIT_MASK;
                    q[0] = 1'b1;
                end
            end
            res.quotient_digit = q;
            if (fin) begin
                res.remainder_out = r;
                model_remainder = '0;
            end else begin
                model_remainder = r;
            end
        end
        return res;
    endfunction

    // track divisor writes and predict on each accepted digit
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_divisor   = FW'(1);
            model_remainder = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                model_divisor = cfg_ch.data;
            if (in_ch.valid && in_ch.ready)
                expected_quotients.push_back(divide_next_digit(in_ch.dividend_digit,
                                                               in_ch.final_digit,
                                                               in_ch.negative));
        end
    end

    // compare every result transfer with the oldest prediction
    always @(posedge i_clk) begin
        div_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_quotients.size() == 0) begin
                $error("result transfer with nothing expected: q=%h rem=%h",
                       out_ch.quotient_digit, out_ch.remainder_out);
                error_count++;
            end else begin
                want = expected_quotients.pop_front();
                checked_count++;
                if (want.divide_by_zero)
                    zero_div_count++;
                if (out_ch.quotient_digit !== want.quotient_digit) begin
                    $error("quotient_digit: expected %h, got %h",
                           want.quotient_digit, out_ch.quotient_digit);
                    error_count++;
                end
                if (out_ch.remainder_out !== want.remainder_out) begin
                    $error("remainder_out: expected %h, got %h",
                           want.remainder_out, out_ch.remainder_out);
                    error_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, out_ch.last);
                    error_count++;
                end
                if (out_ch.quotient_negative !== want.quotient_negative) begin
                    $error("quotient_negative: expected %b, got %b",
                           want.quotient_negative, out_ch.quotient_negative);
                    error_count++;
                end
                if (out_ch.divide_by_zero !== want.divide_by_zero) begin
                    $error("divide_by_zero: expected %b, got %b",
                           want.divide_by_zero, out_ch.divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stall before each result, sometimes only once it shows up
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                if ($urandom_range(0, 1) == 1)
                    do @(posedge i_clk); while (!out_ch.valid);
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // one digit transfer; valid stays up when the next digit follows without a gap
    task automatic send_digit(input logic [FW-1:0] digit, input logic fin, input logic neg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.dividend_digit <= digit;
        in_ch.final_digit    <= fin;
        in_ch.negative       <= neg;
        do @(posedge i_clk); while (!in_ch.ready);
        digit_count++;
        if (fin)
            number_count++;
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_for_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_quotients.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_divisor(input logic [FW-1:0] value);
        wait_for_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        divisor_writes++;
    endtask

    function automatic logic [FW-1:0] pick_divisor();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return FW'(1);
            2:       return FW'(2);
            3:       return FW'(3);
            4:       return FW'(1) << $urandom_range(0, DW - 1);
            5:       return MAX_DIGIT;
            6:       return MAX_DIGIT - FW'($urandom_range(1, 255));
            7, 8:    return FW'(raw[15:0]);
            default: return raw[FW-1:0] & DIGIT_MASK;
        endcase
    endfunction

    function automatic logic [FW-1:0] pick_digit();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return MAX_DIGIT;
            2:       return FW'(raw[7:0]);
            3:       return MAX_DIGIT - FW'(raw[15:0]);
            default: return raw[FW-1:0] & DIGIT_MASK;
        endcase
    endfunction

    // divisor is 1 out of reset: quotient equals the dividend
    task automatic test_reset_divisor();
        send_digit(MAX_DIGIT, 1'b0, 1'b0);
        send_digit('0, 1'b1, 1'b1);
    endtask

    // largest divisor, three, a high power of two and two
    task automatic test_divisor_extremes();
        write_divisor(MAX_DIGIT);
        send_digit(MAX_DIGIT - FW'(1), 1'b0, 1'b0);
        send_digit(MAX_DIGIT, 1'b0, 1'b0);
        send_digit(MAX_DIGIT, 1'b1, 1'b1);
        write_divisor(FW'(3));
        send_digit({(FW/2){2'b10}}, 1'b0, 1'b0);
        send_digit({(FW/2){2'b01}}, 1'b1, 1'b0);
        write_divisor(FW'(1) << (DW - 1));
        send_digit({(FW/4){4'b1100}}, 1'b1, 1'b1);
        write_divisor(FW'(2));
        send_digit(MAX_DIGIT, 1'b1, 1'b1);
    endtask

    // zero divisor flags and clears; the next number must start clean
    task automatic test_zero_divisor();
        write_divisor('0);
        send_digit(MAX_DIGIT, 1'b0, 1'b1);
        send_digit('0, 1'b1, 1'b1);
        write_divisor(FW'(7));
        send_digit('0, 1'b0, 1'b0);
        send_digit(FW'(100), 1'b1, 1'b0);
    endtask

    // running remainder left at or above a smaller new divisor
    task automatic test_divisor_change_mid_number();
        write_divisor(MAX_DIGIT);
        send_digit(MAX_DIGIT - FW'(1), 1'b0, 1'b0);
        write_divisor(FW'(5));
        send_digit(FW'(123), 1'b1, 1'b1);
        write_divisor(FW'(1) << (DW - 1));
        send_digit(MAX_DIGIT, 1'b0, 1'b0);
        write_divisor(FW'(3));
        send_digit(MAX_DIGIT, 1'b1, 1'b0);
    endtask

    // random numbers in phases; a phase may end mid-number before the divisor changes
    task automatic test_random_numbers();
        int            sent;
        int            phase_items;
        int            len;
        logic          neg;
        logic          fin;
        logic [FW-1:0] dvs;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            dvs = pick_divisor();
            write_divisor(dvs);
            no_idle = ($urandom_range(0, 3) == 0);
            phase_items = (dvs == '0) ? $urandom_range(4, 12) : $urandom_range(40, 160);
            while (phase_items > 0 && sent < RANDOM_ITEMS) begin
                len = $urandom_range(1, 6);
                neg = 1'($urandom_range(0, 1));
                for (int k = 0; k < len && phase_items > 0; k++) begin
                    fin = (k == len - 1);
                    // occasional broken framing: early end or missing end
                    if ($urandom_range(0, 15) == 0)
                        fin = ~fin;
                    send_digit(pick_digit(), fin,
                               ($urandom_range(0, 15) == 0) ? ~neg : neg);
                    phase_items--;
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.dividend_digit <= '0;
        in_ch.final_digit    <= 1'b0;
        in_ch.negative       <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.data          <= '0;
        i_rst_n              <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_divisor();
        test_divisor_extremes();
        test_zero_divisor();
        test_divisor_change_mid_number();
        test_random_numbers();

        // drain, then watch a while for stray results
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_quotients.size() != 0) begin
            $error("%0d results never arrived", expected_quotients.size());
            error_count++;
        end

        $display("Sent %0d digits forming %0d numbers under %0d divisor settings.",
                 digit_count, number_count, divisor_writes + 1);
        $display("Checked %0d results, %0d of them with a zero divisor; %0d mismatches.",
                 checked_count, zero_div_count, error_count);
        if (error_count == 0)
            $display("tb_bignum_divide_by_digit: PASS");
        else
            $display("tb_bignum_divide_by_digit: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bdd_pkg.sv
hw/rtl/bdd_if.sv
hw/rtl/bignum_divide_by_digit.sv
hw/rtl/bdd_checker.sv
tb/tb_bignum_divide_by_digit.sv
